// ===== rtl/iso8601_date_time_parser_macros.svh =====
// ----------------------------------------------------------------------------
// ISO 8601 parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ISO8601_DATE_TIME_PARSER_MACROS_SVH
`define ISO8601_DATE_TIME_PARSER_MACROS_SVH

// Same-cycle implication.
`define IDTP_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define IDTP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/idtp_pkg.sv =====
// ----------------------------------------------------------------------------
// ISO 8601 parser package
// Character codes, field positions, widths and digit folding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package idtp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned YearW  = 14;
  localparam int unsigned AccW   = 7;
  localparam int unsigned PosW   = 5;

  localparam logic [CharW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChNine  = 8'h39;  // '9'
  localparam logic [CharW-1:0] ChDash  = 8'h2D;  // '-'
  localparam logic [CharW-1:0] ChColon = 8'h3A;  // ':'
  localparam logic [CharW-1:0] ChT     = 8'h54;  // 'T'

  // Field positions within the string
  localparam logic [PosW-1:0] PosYearLast  = 5'd3;
  localparam logic [PosW-1:0] PosDash1     = 5'd4;
  localparam logic [PosW-1:0] PosMonLast   = 5'd6;
  localparam logic [PosW-1:0] PosDash2     = 5'd7;
  localparam logic [PosW-1:0] PosDayLast   = 5'd9;
  localparam logic [PosW-1:0] PosTMark     = 5'd10;
  localparam logic [PosW-1:0] PosHourLast  = 5'd12;
  localparam logic [PosW-1:0] PosColon     = 5'd13;
  localparam logic [PosW-1:0] PosMinLast   = 5'd15;
  localparam logic [PosW-1:0] PosMax       = 5'd16;
  localparam logic [PosW-1:0] DateLen      = 5'd10;

  localparam logic [YearW-1:0] YearFloorRst = 14'd2000;
  localparam logic [AccW-1:0]  MonthMax     = 7'd12;
  localparam logic [AccW-1:0]  DayMax       = 7'd31;
  localparam logic [AccW-1:0]  HourMax      = 7'd23;
  localparam logic [AccW-1:0]  MinuteMax    = 7'd59;

  function automatic logic [AccW-1:0] fold_acc(input logic [AccW-1:0] acc,
                                               input logic [3:0] dig);
    logic [AccW+2:0] s;
    s = (AccW+3)'({acc, 3'b000}) + (AccW+3)'({acc, 1'b0}) + (AccW+3)'(dig);
    return s[AccW-1:0];
  endfunction

  function automatic logic [YearW-1:0] fold_year(input logic [YearW-1:0] acc,
                                                 input logic [3:0] dig);
    logic [YearW+2:0] s;
    s = (YearW+3)'({acc, 3'b000}) + (YearW+3)'({acc, 1'b0}) + (YearW+3)'(dig);
    return s[YearW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/iso8601_date_time_parser.sv =====
// Result: registered into the output register on the transfer of the character
// marked last, and shown in the cycle after that transfer.
// Throughput: one character per cycle unless a held result (out_ready low) stalls in_ready;
// the per-character class check and one decimal fold sit between the parse state registers and the result register.
// Reset (rst_n low, synchronous): parse state cleared, year floor back to 2000,
// output register empty.
// ----------------------------------------------------------------------------
// ISO 8601 date/time parser
// Parses YYYY-MM-DD[THH:MM] one character per transfer, one result per string.
// ----------------------------------------------------------------------------
`default_nettype none

`include "iso8601_date_time_parser_macros.svh"

module iso8601_date_time_parser (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [idtp_pkg::YearW-1:0]      cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [idtp_pkg::CharW-1:0]      in_char_code,
  input  wire logic                            in_last,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_valid_res,
  output logic [idtp_pkg::YearW-1:0]           out_year,
  output logic [3:0]                           out_month,
  output logic [4:0]                           out_day,
  output logic [4:0]                           out_hour,
  output logic [5:0]                           out_minute
);

  logic [idtp_pkg::YearW-1:0] year_floor_r;

  logic [idtp_pkg::PosW-1:0]  pos_r, pos_nxt, pos_upd;
  logic [idtp_pkg::YearW-1:0] year_acc_r, year_acc_nxt, year_upd;
  logic [idtp_pkg::AccW-1:0]  month_acc_r, month_acc_nxt, month_upd;
  logic [idtp_pkg::AccW-1:0]  day_acc_r, day_acc_nxt, day_upd;
  logic [idtp_pkg::AccW-1:0]  hour_acc_r, hour_acc_nxt, hour_upd;
  logic [idtp_pkg::AccW-1:0]  minute_acc_r, minute_acc_nxt, minute_upd;
  logic date_ok_r, date_ok_nxt, date_ok_upd;
  logic time_ok_r, time_ok_nxt, time_ok_upd;
  logic tmark_r, tmark_nxt, tmark_upd;

  logic       accept;
  logic       is_digit;
  logic [3:0] digit;
  logic       date_good, time_chk, time_good;

  logic                       out_valid_r;
  logic                       res_valid_r;
  logic [idtp_pkg::YearW-1:0] res_year_r;
  logic [3:0]                 res_month_r;
  logic [4:0]                 res_day_r;
  logic [4:0]                 res_hour_r;
  logic [5:0]                 res_minute_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_digit = (in_char_code >= idtp_pkg::ChZero) && (in_char_code <= idtp_pkg::ChNine);
  assign digit    = 4'(in_char_code - idtp_pkg::ChZero);

  // Per-character update of the parse state
  always_comb begin
    year_upd    = year_acc_r;
    month_upd   = month_acc_r;
    day_upd     = day_acc_r;
    hour_upd    = hour_acc_r;
    minute_upd  = minute_acc_r;
    date_ok_upd = date_ok_r;
    time_ok_upd = time_ok_r;
    tmark_upd   = tmark_r;
    if (pos_r <= idtp_pkg::PosYearLast) begin
      if (is_digit) year_upd = idtp_pkg::fold_year(year_acc_r, digit);
      else          date_ok_upd = 1'b0;
    end else if (pos_r == idtp_pkg::PosDash1 || pos_r == idtp_pkg::PosDash2) begin
      if (in_char_code != idtp_pkg::ChDash) date_ok_upd = 1'b0;
    end else if (pos_r <= idtp_pkg::PosMonLast) begin
      if (is_digit) month_upd = idtp_pkg::fold_acc(month_acc_r, digit);
      else          date_ok_upd = 1'b0;
    end else if (pos_r <= idtp_pkg::PosDayLast) begin
      if (is_digit) day_upd = idtp_pkg::fold_acc(day_acc_r, digit);
      else          date_ok_upd = 1'b0;
    end else if (pos_r == idtp_pkg::PosTMark) begin
      tmark_upd = (in_char_code == idtp_pkg::ChT);
    end else if (pos_r <= idtp_pkg::PosHourLast) begin
      if (is_digit) hour_upd = idtp_pkg::fold_acc(hour_acc_r, digit);
      else          time_ok_upd = 1'b0;
    end else if (pos_r == idtp_pkg::PosColon) begin
      if (in_char_code != idtp_pkg::ChColon) time_ok_upd = 1'b0;
    end else if (pos_r <= idtp_pkg::PosMinLast) begin
      if (is_digit) minute_upd = idtp_pkg::fold_acc(minute_acc_r, digit);
      else          time_ok_upd = 1'b0;
    end
    pos_upd = (pos_r < idtp_pkg::PosMax) ? pos_r + 5'd1 : idtp_pkg::PosMax;
  end

  // Result checks on the updated state
  assign date_good = (pos_upd >= idtp_pkg::DateLen) && date_ok_upd &&
                     (month_upd != '0) && (month_upd <= idtp_pkg::MonthMax) &&
                     (day_upd != '0) && (day_upd <= idtp_pkg::DayMax) &&
                     (year_upd >= year_floor_r);
  assign time_chk  = (pos_upd == idtp_pkg::PosMax) && tmark_upd;
  assign time_good = time_ok_upd && (hour_upd <= idtp_pkg::HourMax) &&
                     (minute_upd <= idtp_pkg::MinuteMax);

  // Next state: hold when idle, clear after the last character
  always_comb begin
    pos_nxt        = pos_r;
    year_acc_nxt   = year_acc_r;
    month_acc_nxt  = month_acc_r;
    day_acc_nxt    = day_acc_r;
    hour_acc_nxt   = hour_acc_r;
    minute_acc_nxt = minute_acc_r;
    date_ok_nxt    = date_ok_r;
    time_ok_nxt    = time_ok_r;
    tmark_nxt      = tmark_r;
    if (accept) begin
      if (in_last) begin
        pos_nxt        = '0;
        year_acc_nxt   = '0;
        month_acc_nxt  = '0;
        day_acc_nxt    = '0;
        hour_acc_nxt   = '0;
        minute_acc_nxt = '0;
        date_ok_nxt    = 1'b1;
        time_ok_nxt    = 1'b1;
        tmark_nxt      = 1'b0;
      end else begin
        pos_nxt        = pos_upd;
        year_acc_nxt   = year_upd;
        month_acc_nxt  = month_upd;
        day_acc_nxt    = day_upd;
        hour_acc_nxt   = hour_upd;
        minute_acc_nxt = minute_upd;
        date_ok_nxt    = date_ok_upd;
        time_ok_nxt    = time_ok_upd;
        tmark_nxt      = tmark_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_floor_r <= idtp_pkg::YearFloorRst;
      pos_r        <= '0;
      year_acc_r   <= '0;
      month_acc_r  <= '0;
      day_acc_r    <= '0;
      hour_acc_r   <= '0;
      minute_acc_r <= '0;
      date_ok_r    <= 1'b1;
      time_ok_r    <= 1'b1;
      tmark_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) year_floor_r <= cfg_wr_data;
      pos_r        <= pos_nxt;
      year_acc_r   <= year_acc_nxt;
      month_acc_r  <= month_acc_nxt;
      day_acc_r    <= day_acc_nxt;
      hour_acc_r   <= hour_acc_nxt;
      minute_acc_r <= minute_acc_nxt;
      date_ok_r    <= date_ok_nxt;
      time_ok_r    <= time_ok_nxt;
      tmark_r      <= tmark_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last) begin
      res_valid_r  <= date_good && (!time_chk || time_good);
      res_year_r   <= date_good ? year_upd : '0;
      res_month_r  <= date_good ? month_upd[3:0] : '0;
      res_day_r    <= date_good ? day_upd[4:0] : '0;
      res_hour_r   <= (date_good && time_chk && time_good) ? hour_upd[4:0] : '0;
      res_minute_r <= (date_good && time_chk && time_good) ? minute_upd[5:0] : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = res_valid_r;
  assign out_year      = res_year_r;
  assign out_month     = res_month_r;
  assign out_day       = res_day_r;
  assign out_hour      = res_hour_r;
  assign out_minute    = res_minute_r;

  `IDTP_ASSERT_IMPL(a_pos_sat, 1'b1, pos_r <= idtp_pkg::PosMax, "position above saturation")
  `IDTP_ASSERT_NEXT(a_clear_after_last, accept && in_last, pos_r == '0 && date_ok_r && time_ok_r && !tmark_r, "parse state not cleared after last transfer")
  `IDTP_ASSERT_IMPL(a_fail_zero, out_valid_r && res_month_r == '0, !res_valid_r && res_year_r == '0 && res_day_r == '0 && res_hour_r == '0 && res_minute_r == '0, "failed date with nonzero fields")
  `IDTP_ASSERT_IMPL(a_time_implies_ok, out_valid_r && (res_hour_r != '0 || res_minute_r != '0), res_valid_r && res_month_r != '0, "time fields set on invalid result")

endmodule

`default_nettype wire
